>>> sv/mrfgd_pkg.sv
// Package for the Modbus RTU frame gap detector.
// Holds the result beat layout, register indexes and the baud gap table.
// No dependencies.
`default_nettype none

package mrfgd_pkg;

  localparam int unsigned LEVEL_W   = 6;
  localparam int unsigned SIL_W     = 8;
  localparam int unsigned GAP_W     = 5;
  localparam int unsigned BAUD_W    = 4;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 4;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [SIL_W-1:0]  SILENCE_MAX   = 8'd200;
  localparam logic [BAUD_W-1:0] BAUD_RESET    = 4'd2;
  localparam logic [BAUD_W-1:0] BAUD_FALLBACK = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE    = 8'd0,
    REG_BAUD_CODE = 8'd1
  } cfg_reg_t;

  // Result beat, listed from the highest bit down.
  typedef struct packed {
    logic [LEVEL_W-1:0] frame_length;
    logic               frame_ready;
    logic               frame_open;
    logic               flush;
    logic [LEVEL_W-1:0] read_count;
    logic               frame_done;
  } result_t;

  // Allowed silence in ticks per baud code; unknown codes behave as the fallback.
  function automatic logic [GAP_W-1:0] gap_limit(input logic [BAUD_W-1:0] code);
    logic [GAP_W-1:0] g;
    case (code)
      4'd0:    g = 5'd17;
      4'd1:    g = 5'd8;
      4'd2:    g = 5'd5;
      4'd3:    g = 5'd3;
      4'd4:    g = 5'd2;
      4'd5:    g = 5'd1;
      4'd6:    g = 5'd1;
      4'd7:    g = 5'd1;
      4'd8:    g = 5'd0;
      4'd9:    g = 5'd0;
      4'd10:   g = 5'd0;
      default: g = 5'd5;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> sv/modbus_rtu_frame_gap_detector_top.sv
// Modbus RTU frame gap detector, top level.
// Depends on mrfgd_pkg for the result layout, register indexes and gap table.
//
// Usage:
//   in_*  : one beat per 1 ms tick, tdata[5:0] = receive FIFO fill level.
//   out_* : one result beat per tick, tdata from bit 0 up: frame_done,
//           read_count[5:0], flush, frame_open, frame_ready, frame_length[5:0].
//   cfg_* : register writes, index 0 = enable, index 1 = baud_code; always ready.
// The result for a tick is on out_* in the cycle after the tick is
// accepted. Throughput: one tick per cycle; the tick's state update and its
// result are formed in one pass of compare logic into the output register.
// A tick is taken while the output register is empty or being drained, so a
// stalled receiver holds its beat and stops new ticks until it drains.
// Reset: enable=0, baud_code=2, silence count, previous level, flags and
// held length cleared, output register empty.
`default_nettype none

module modbus_rtu_frame_gap_detector_top #(
  parameter int unsigned FIFO_DEPTH = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // in_tdata: fifo_level[5:0], bits [7:6] zero
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [mrfgd_pkg::IN_DATA_W-1:0]   in_tdata,
  // out_tdata: frame_done, read_count[5:0], flush, frame_open, frame_ready,
  //            frame_length[5:0]
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [mrfgd_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [mrfgd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [mrfgd_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import mrfgd_pkg::*;

  localparam logic [SIL_W-1:0] DEPTH_C = SIL_W'(FIFO_DEPTH);

  logic               enable_r;
  logic [BAUD_W-1:0]  baud_r;
  logic [SIL_W-1:0]   sil_r, sil_nxt;
  logic [LEVEL_W-1:0] prev_r, prev_nxt;
  logic               started_r, started_nxt;
  logic               finished_r, finished_nxt;
  logic [LEVEL_W-1:0] len_r, len_nxt;
  logic               out_valid_r;
  result_t            res_r, res_nxt;

  logic               in_beat;
  logic [LEVEL_W-1:0] lvl;
  logic [SIL_W-1:0]   sil_inc;
  logic               past_gap;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_beat    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  always_comb begin
    logic done, flush;
    logic [LEVEL_W-1:0] count;
    done  = 1'b0;
    flush = 1'b0;
    count = '0;
    // clamp to FIFO capacity
    if ({2'b00, in_tdata[LEVEL_W-1:0]} > DEPTH_C) begin
      lvl = DEPTH_C[LEVEL_W-1:0];
    end else begin
      lvl = in_tdata[LEVEL_W-1:0];
    end
    sil_inc  = (sil_r < SILENCE_MAX) ? sil_r + 8'd1 : sil_r;
    past_gap = sil_inc > {3'b000, gap_limit(baud_r)};

    sil_nxt      = sil_r;
    prev_nxt     = prev_r;
    started_nxt  = started_r;
    finished_nxt = finished_r;
    len_nxt      = len_r;

    if (enable_r) begin
      sil_nxt  = sil_inc;
      prev_nxt = lvl;
      if (lvl != '0 && prev_r == '0) begin
        if (past_gap) begin
          len_nxt      = '0;
          started_nxt  = 1'b1;
          finished_nxt = 1'b0;
          sil_nxt      = '0;
        end
      end else if (lvl > prev_r) begin
        sil_nxt = '0;
      end else if (lvl == prev_r && lvl != '0) begin
        if (past_gap) begin
          if (started_r) begin
            done         = 1'b1;
            count        = lvl;
            len_nxt      = lvl;
            finished_nxt = 1'b1;
          end else begin
            flush = 1'b1;
          end
          started_nxt = 1'b0;
        end
      end
    end

    res_nxt.frame_done   = done;
    res_nxt.read_count   = count;
    res_nxt.flush        = flush;
    res_nxt.frame_open   = started_nxt;
    res_nxt.frame_ready  = finished_nxt;
    res_nxt.frame_length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      baud_r      <= BAUD_RESET;
      sil_r       <= '0;
      prev_r      <= '0;
      started_r   <= 1'b0;
      finished_r  <= 1'b0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ENABLE:    enable_r <= cfg_data[0];
          REG_BAUD_CODE: baud_r   <= cfg_data;
          default:       ;
        endcase
      end
      if (in_beat) begin
        sil_r      <= sil_nxt;
        prev_r     <= prev_nxt;
        started_r  <= started_nxt;
        finished_r <= finished_nxt;
        len_r      <= len_nxt;
      end
      if (in_beat) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/mrfgd_checker.sv
// Port-level checker for the Modbus RTU frame gap detector, with its bind.
// Depends on mrfgd_pkg for the result layout.
`default_nettype none

module mrfgd_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [mrfgd_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import mrfgd_pkg::*;

  result_t res;
  assign res = out_tdata;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted tick gave no result");

  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.frame_done |-> res.read_count == res.frame_length &&
      res.frame_ready && !res.frame_open && !res.flush)
    else $error("inconsistent frame handover");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res.frame_done |-> res.read_count == '0 &&
      !(res.frame_open && res.frame_ready))
    else $error("read count or flags wrong outside handover");

endmodule

bind modbus_rtu_frame_gap_detector_top mrfgd_checker u_mrfgd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
